// ===== hw/rtl/pcicfg_pkg.sv =====
// Shared types and constants for the PCI type-0 configuration space responder.
// No dependencies; used by the top level and its port checker.
package pcicfg_pkg;

  localparam int MAX_DEVICES  = 32;
  localparam int SLOT_W       = $clog2(MAX_DEVICES);
  localparam int CONFIG_BYTES = 256;
  localparam int OFF_W        = 12;

  typedef enum logic [1:0] {
    CFG_DEVICE_COUNT   = 2'd0,
    CFG_VENDOR_CODE    = 2'd1,
    CFG_DEVICE_CODE    = 2'd2,
    CFG_SUBSYSTEM_CODE = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_BAD_REG = 1'b1
  } status_t;

  // Reset values of the configuration registers and per-device state
  localparam logic [5:0]  DEVICE_COUNT_RESET   = 6'd4;
  localparam logic [15:0] VENDOR_CODE_RESET    = 16'he1a5;
  localparam logic [15:0] DEVICE_CODE_RESET    = 16'hd0c5;
  localparam logic [15:0] SUBSYSTEM_CODE_RESET = 16'hd0c5;
  localparam logic [15:0] CMD_RESET            = 16'h0006;
  localparam logic [1:0]  PM_RESET             = 2'b00;

  // Writable register offsets
  localparam logic [OFF_W-1:0] OFF_COMMAND = 12'h004;
  localparam logic [OFF_W-1:0] OFF_PMCSR   = 12'h064;
  localparam logic [2:0]       WR_BYTES    = 3'd2;

  // Fixed header image bytes
  localparam logic [7:0] HDR_STATUS_LO  = 8'h10;
  localparam logic [7:0] HDR_REVISION   = 8'ha1;
  localparam logic [15:0] HDR_CLASS     = 16'h0302;
  localparam logic [7:0] HDR_CACHE_LINE = 8'h10;
  localparam logic [7:0] HDR_CAP_PTR    = 8'h60;
  localparam logic [7:0] HDR_INT_LINE   = 8'hff;
  localparam logic [7:0] HDR_INT_PIN    = 8'h01;
  localparam logic [7:0] CAP_ID_PM      = 8'h01;
  localparam logic [7:0] CAP_MSI_OFF    = 8'h68;
  localparam logic [7:0] PM_PMC         = 8'h03;
  localparam logic [7:0] CAP_ID_MSI     = 8'h05;
  localparam logic [7:0] CAP_PCIE_OFF   = 8'h78;
  localparam logic [7:0] MSI_CTRL_LO    = 8'h80;
  localparam logic [7:0] CAP_ID_PCIE    = 8'h10;
  localparam logic [7:0] PCIE_CAP_LO    = 8'h02;
  localparam logic [7:0] PCIE_DEVCAP_LO = 8'h10;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       bus_number;
    logic [7:0]       dev_function;
    logic [OFF_W-1:0] byte_offset;
    logic [2:0]       access_bytes;
    logic [31:0]      write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    status_t     status;
  } out_item_t;

endpackage

// ===== hw/rtl/pci_config_space_responder_top.sv =====
// Accepts one configuration read or write per cycle unless the result side stalls;
// a result passes through the input register and then the result register before
// it reaches the output. Each slot's command word and power-state bits
// live in flip-flops beside the decoder, so a write is visible to the very next
// access. Stalls on the result side back up through the input register;
// configuration writes are taken at any time.
// Depends on pcicfg_pkg.
module pci_config_space_responder_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pcicfg_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pcicfg_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_wdata
);

  function automatic logic [7:0] image_byte(
    input logic [7:0]  off,
    input logic [15:0] vendor,
    input logic [15:0] device,
    input logic [15:0] subsys,
    input logic [15:0] cmd,
    input logic [1:0]  pm
  );
    logic [7:0] b;
    b = 8'h00;
    unique case (off)
      8'h00:   b = vendor[7:0];
      8'h01:   b = vendor[15:8];
      8'h02:   b = device[7:0];
      8'h03:   b = device[15:8];
      8'h04:   b = cmd[7:0];
      8'h05:   b = cmd[15:8];
      8'h06:   b = pcicfg_pkg::HDR_STATUS_LO;
      8'h08:   b = pcicfg_pkg::HDR_REVISION;
      8'h0a:   b = pcicfg_pkg::HDR_CLASS[7:0];
      8'h0b:   b = pcicfg_pkg::HDR_CLASS[15:8];
      8'h0c:   b = pcicfg_pkg::HDR_CACHE_LINE;
      8'h2c:   b = vendor[7:0];
      8'h2d:   b = vendor[15:8];
      8'h2e:   b = subsys[7:0];
      8'h2f:   b = subsys[15:8];
      8'h34:   b = pcicfg_pkg::HDR_CAP_PTR;
      8'h3c:   b = pcicfg_pkg::HDR_INT_LINE;
      8'h3d:   b = pcicfg_pkg::HDR_INT_PIN;
      8'h60:   b = pcicfg_pkg::CAP_ID_PM;
      8'h61:   b = pcicfg_pkg::CAP_MSI_OFF;
      8'h62:   b = pcicfg_pkg::PM_PMC;
      8'h64:   b = {6'd0, pm};
      8'h68:   b = pcicfg_pkg::CAP_ID_MSI;
      8'h69:   b = pcicfg_pkg::CAP_PCIE_OFF;
      8'h6a:   b = pcicfg_pkg::MSI_CTRL_LO;
      8'h78:   b = pcicfg_pkg::CAP_ID_PCIE;
      8'h7a:   b = pcicfg_pkg::PCIE_CAP_LO;
      8'h7c:   b = pcicfg_pkg::PCIE_DEVCAP_LO;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Configuration registers
  logic [5:0]  dev_count_r;
  logic [15:0] vendor_r;
  logic [15:0] device_r;
  logic [15:0] subsys_r;

  // Per-slot state
  logic [15:0] cmd_r [pcicfg_pkg::MAX_DEVICES];
  logic [1:0]  pm_r  [pcicfg_pkg::MAX_DEVICES];

  // Pipeline registers
  logic                  s1_valid_r, s1_valid_nxt;
  pcicfg_pkg::in_item_t  s1_item_r;
  logic                  out_valid_r, out_valid_nxt;
  pcicfg_pkg::out_item_t out_item_r, out_item_nxt;

  logic                          adv;
  logic                          take_in;
  logic [pcicfg_pkg::SLOT_W-1:0] slot;
  logic [2:0]                    func;
  logic                          absent;
  logic [pcicfg_pkg::OFF_W:0]    end_off;
  logic                          out_of_range;
  logic                          size_ok;
  logic [31:0]                   rd_word;
  logic [7:0]                    rd_byte [4];
  logic                          wr_commit;
  logic                          wr_cmd;
  logic                          wr_pm;

  // Output slot frees when empty or being taken
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign take_in   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign slot    = s1_item_r.dev_function[7:3];
  assign func    = s1_item_r.dev_function[2:0];
  // A count above the slot range leaves every slot present
  assign absent  = (s1_item_r.bus_number != 8'd0) || (func != 3'd0) ||
                   ({1'b0, slot} >= dev_count_r);
  assign end_off = {1'b0, s1_item_r.byte_offset} +
                   {{(pcicfg_pkg::OFF_W-2){1'b0}}, s1_item_r.access_bytes};
  assign out_of_range = end_off > (pcicfg_pkg::OFF_W+1)'(pcicfg_pkg::CONFIG_BYTES);
  assign size_ok = (s1_item_r.access_bytes == 3'd1) ||
                   (s1_item_r.access_bytes == 3'd2) ||
                   (s1_item_r.access_bytes == 3'd4);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_byte[i] = image_byte(s1_item_r.byte_offset[7:0] + 8'(i), vendor_r, device_r,
                              subsys_r, cmd_r[slot], pm_r[slot]);
      rd_word[8*i +: 8] = (3'(i) < s1_item_r.access_bytes) ? rd_byte[i] : 8'h00;
    end
  end

  assign wr_commit = s1_valid_r && adv && !absent && !out_of_range &&
                     (s1_item_r.kind == pcicfg_pkg::KIND_WRITE) &&
                     (s1_item_r.access_bytes == pcicfg_pkg::WR_BYTES);
  assign wr_cmd    = wr_commit && (s1_item_r.byte_offset == pcicfg_pkg::OFF_COMMAND);
  assign wr_pm     = wr_commit && (s1_item_r.byte_offset == pcicfg_pkg::OFF_PMCSR);

  always_comb begin
    out_item_nxt.read_data = 32'd0;
    out_item_nxt.status    = pcicfg_pkg::STATUS_OK;
    if (absent) begin
      if (s1_item_r.kind == pcicfg_pkg::KIND_READ) begin
        out_item_nxt.read_data = '1;
      end
    end else if (out_of_range) begin
      out_item_nxt.status = pcicfg_pkg::STATUS_BAD_REG;
    end else if (s1_item_r.kind == pcicfg_pkg::KIND_READ) begin
      if (size_ok) begin
        out_item_nxt.read_data = rd_word;
      end else begin
        out_item_nxt.status = pcicfg_pkg::STATUS_BAD_REG;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take_in) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_count_r <= pcicfg_pkg::DEVICE_COUNT_RESET;
      vendor_r    <= pcicfg_pkg::VENDOR_CODE_RESET;
      device_r    <= pcicfg_pkg::DEVICE_CODE_RESET;
      subsys_r    <= pcicfg_pkg::SUBSYSTEM_CODE_RESET;
    end else if (cfg_we) begin
      unique case (pcicfg_pkg::cfg_reg_t'(cfg_index))
        pcicfg_pkg::CFG_DEVICE_COUNT:   dev_count_r <= cfg_wdata[5:0];
        pcicfg_pkg::CFG_VENDOR_CODE:    vendor_r    <= cfg_wdata;
        pcicfg_pkg::CFG_DEVICE_CODE:    device_r    <= cfg_wdata;
        pcicfg_pkg::CFG_SUBSYSTEM_CODE: subsys_r    <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pcicfg_pkg::MAX_DEVICES; i++) begin
        cmd_r[i] <= pcicfg_pkg::CMD_RESET;
        pm_r[i]  <= pcicfg_pkg::PM_RESET;
      end
    end else begin
      if (wr_cmd) begin
        cmd_r[slot] <= s1_item_r.write_data[15:0];
      end
      if (wr_pm) begin
        pm_r[slot] <= s1_item_r.write_data[1:0];
      end
    end
  end

endmodule

// ===== hw/rtl/pcicfg_checker.sv =====
// Port-level checks for the configuration space responder, bound to its top.
// Depends on pcicfg_pkg.
module pcicfg_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input pcicfg_pkg::out_item_t out_data
);

  // Held result stays put until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input backs up only when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result slot");

  // A bad register never carries data
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == pcicfg_pkg::STATUS_BAD_REG) |->
    out_data.read_data == 32'd0)
    else $error("bad register result with nonzero data");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pci_config_space_responder_top pcicfg_checker u_pcicfg_checker (.*);
